>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DLLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/dlle_pkg.sv
// Shared types and constants for the linked list engine.
// No dependencies.
package dlle_pkg;

  localparam int unsigned DefCapacity = 32;
  localparam int unsigned KeyW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_DEL_KEY   = 2'd1,
    CMD_DEL_FIRST = 2'd2,
    CMD_DEL_LAST  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_TAIL = 2'd1,
    RD_NEXT = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic    load;
    logic    insert;
    logic    rd_en;
    rd_src_e rd_src;
    logic    unlink;
    logic    walk_start;
    logic    walk_step;
    logic    set_status;
    status_e status;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic cnt_zero;
    logic full;
    logic key_match;
    logic walk_last;
  } stat_t;

endpackage

>>> hdl/dlle_datapath.sv
// Datapath: node memories, head/tail/count/free-mask registers, read port.
// Depends on dlle_pkg.
module dlle_datapath #(
  parameter int unsigned CAPACITY = dlle_pkg::DefCapacity
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dlle_pkg::ctrl_t                ctrl_i,
  output dlle_pkg::stat_t                stat_o,
  input  logic [dlle_pkg::KeyW-1:0]      key_i,
  input  dlle_pkg::cmd_e                 cmd_i,
  output logic [dlle_pkg::KeyW-1:0]      elem_key_o,
  output dlle_pkg::status_e              status_o
);
  import dlle_pkg::*;

  localparam int unsigned PtrW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [KeyW-1:0] key_mem  [CAPACITY];
  logic [PtrW-1:0] next_mem [CAPACITY];
  logic [PtrW-1:0] prev_mem [CAPACITY];

  logic [KeyW-1:0]     key_q, rkey_q;
  cmd_e                cmd_q;
  status_e             status_q;
  logic [PtrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0]     cur_q, rnext_q, rprev_q, rd_addr, slot_free;
  logic [CntW-1:0]     cnt_q, cnt_d, idx_q;
  logic [CAPACITY-1:0] free_q, free_d;
  logic                multi;

  always_comb begin
    logic found;
    found = 1'b0;
    slot_free = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!found && free_q[i]) begin
        slot_free = PtrW'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    case (ctrl_i.rd_src)
      RD_HEAD: rd_addr = head_q;
      RD_TAIL: rd_addr = tail_q;
      RD_NEXT: rd_addr = rnext_q;
      default: rd_addr = head_q;
    endcase
  end

  assign multi = (cnt_q > CntW'(1));

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    free_d = free_q;
    if (ctrl_i.insert) begin
      free_d[slot_free] = 1'b0;
      head_d = slot_free;
      if (cnt_q == '0) tail_d = slot_free;
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl_i.unlink) begin
      free_d[cur_q] = 1'b1;
      if (!multi) begin
        cnt_d = '0;
      end else begin
        if (cur_q == head_q) head_d = rnext_q;
        if (cur_q == tail_q) tail_d = rprev_q;
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      free_q   <= '1;
      idx_q    <= '0;
      cur_q    <= '0;
      cmd_q    <= CMD_INSERT;
      status_q <= ST_OK;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      free_q <= free_d;
      if (ctrl_i.rd_en) cur_q <= rd_addr;
      if (ctrl_i.walk_start) begin
        idx_q <= '0;
      end else if (ctrl_i.walk_step) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (ctrl_i.load) begin
        cmd_q    <= cmd_i;
        status_q <= ST_OK;
      end else if (ctrl_i.set_status) begin
        status_q <= ctrl_i.status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) key_q <= key_i;
    if (ctrl_i.insert) begin
      key_mem[slot_free]  <= key_q;
      next_mem[slot_free] <= head_q;
      if (cnt_q != '0) prev_mem[head_q] <= slot_free;
    end else if (ctrl_i.unlink && multi) begin
      if (cur_q != head_q) next_mem[rprev_q] <= rnext_q;
      if (cur_q != tail_q) prev_mem[rnext_q] <= rprev_q;
    end
    if (ctrl_i.rd_en) begin
      rkey_q  <= key_mem[rd_addr];
      rnext_q <= next_mem[rd_addr];
      rprev_q <= prev_mem[rd_addr];
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.full      = (cnt_q == CntW'(CAPACITY));
  assign stat_o.key_match = (rkey_q == key_q);
  assign stat_o.walk_last = (idx_q == cnt_q - CntW'(1));

  assign elem_key_o = (cnt_q == '0) ? '0 : rkey_q;
  assign status_o   = status_q;

endmodule

>>> hdl/dlle_ctrl.sv
// Command sequencer: decode, key search, unlink and list dump.
// Depends on dlle_pkg.
module dlle_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_last_o,
  output logic            out_empty_o,
  input  dlle_pkg::stat_t stat_i,
  output dlle_pkg::ctrl_t ctrl_o
);
  import dlle_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SRCH   = 3'd2;
  localparam logic [2:0] S_UNL    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DOUT   = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DOUT);
  assign out_empty_o = stat_i.cnt_zero;
  assign out_last_o  = stat_i.cnt_zero | stat_i.walk_last;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DSTART;
        if (stat_i.cmd == CMD_INSERT) begin
          if (stat_i.full) begin
            ctrl_o.set_status = 1'b1;
            ctrl_o.status = ST_FULL;
          end else begin
            ctrl_o.insert = 1'b1;
          end
        end else if (stat_i.cnt_zero) begin
          ctrl_o.set_status = 1'b1;
          ctrl_o.status = ST_EMPTY;
        end else begin
          ctrl_o.rd_en = 1'b1;
          case (stat_i.cmd)
            CMD_DEL_KEY: begin
              ctrl_o.rd_src = RD_HEAD;
              ctrl_o.walk_start = 1'b1;
              state_d = S_SRCH;
            end
            CMD_DEL_LAST: begin
              ctrl_o.rd_src = RD_TAIL;
              state_d = S_UNL;
            end
            default: begin
              ctrl_o.rd_src = RD_HEAD;
              state_d = S_UNL;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (stat_i.key_match) begin
          ctrl_o.unlink = 1'b1;
          state_d = S_DSTART;
        end else if (stat_i.walk_last) begin
          ctrl_o.set_status = 1'b1;
          ctrl_o.status = ST_NOT_FOUND;
          state_d = S_DSTART;
        end else begin
          ctrl_o.rd_en = 1'b1;
          ctrl_o.rd_src = RD_NEXT;
          ctrl_o.walk_step = 1'b1;
        end
      end
      S_UNL: begin
        ctrl_o.unlink = 1'b1;
        state_d = S_DSTART;
      end
      S_DSTART: begin
        if (!stat_i.cnt_zero) begin
          ctrl_o.rd_en = 1'b1;
          ctrl_o.rd_src = RD_HEAD;
          ctrl_o.walk_start = 1'b1;
        end
        state_d = S_DOUT;
      end
      S_DOUT: begin
        if (out_ready_i) begin
          if (out_last_o) begin
            state_d = S_IDLE;
          end else begin
            ctrl_o.rd_en = 1'b1;
            ctrl_o.rd_src = RD_NEXT;
            ctrl_o.walk_step = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/doubly_linked_list_engine.sv
// Linked list engine: one command per item, then a front-to-back dump.
// A command is loaded, then executed: insert, or any command on an empty list, goes
// straight to the dump; delete first/last reads the end node, then unlinks it; delete
// by key walks from the head one node per step (up to CAPACITY) until a match or the
// last node. One command at a time; the dump gives one result a cycle while m_axis_tready is high.
// Reset clears head, tail, count and the free mask at once; no clearing pass.
module doubly_linked_list_engine #(
  parameter int unsigned CAPACITY = dlle_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] key_value
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] element_key
  output logic        m_axis_tlast,  // end_of_dump
  output logic [2:0]  m_axis_tuser   // [0] list_empty, [2:1] op_status
);
  import dlle_pkg::*;

  ctrl_t   ctrl;
  stat_t   stat;
  status_e status;
  logic    empty;

  dlle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .out_empty_o (empty),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dlle_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .key_i      (s_axis_tdata),
    .cmd_i      (cmd_e'(s_axis_tuser)),
    .elem_key_o (m_axis_tdata),
    .status_o   (status)
  );

  assign m_axis_tuser = {status, empty};

endmodule

>>> hdl/dlle_checker.sv
// Port-level checks for the linked list engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module dlle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);
  `DLLE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `DLLE_ASSERT_IMP(a_one_side, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid)
  `DLLE_ASSERT_IMP(a_empty_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
  `DLLE_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0)
  `DLLE_ASSERT_NXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind doubly_linked_list_engine dlle_checker u_dlle_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for doubly_linked_list_engine: drives list commands,
// predicts every dump item in a scoreboard class. Depends on dlle_pkg and the RTL.
`timescale 1ns / 1ps

import dlle_pkg::*;

typedef struct packed {
  logic [31:0] key;
  logic        last;
  logic        empty;
  status_e     status;
} dump_item_t;

class list_scoreboard;
  localparam int unsigned Cap = DefCapacity;
  logic [31:0] keys[Cap];
  logic [4:0]  nxt[Cap];
  logic [4:0]  prv[Cap];
  logic [4:0]  head, tail;
  int unsigned count;
  logic [Cap-1:0] free_mask;
  dump_item_t dump_q[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    head = 0;
    tail = 0;
    count = 0;
    free_mask = '1;
    errors = 0;
    checked = 0;
  endfunction

  function void unlink(logic [4:0] s);
    logic [4:0] p, n;
    p = prv[s];
    n = nxt[s];
    if (count <= 1) begin
      count = 0;
    end else begin
      if (s == head) head = n;
      else nxt[p] = n;
      if (s == tail) tail = p;
      else prv[n] = s == tail ? prv[n] : p;
      count--;
    end
    free_mask[s] = 1'b1;
  endfunction

  function void note_command(cmd_e cmd, logic [31:0] key);
    status_e st;
    logic [4:0] s;
    bit found;
    dump_item_t r;
    st = ST_OK;
    found = 0;
    if (cmd == CMD_INSERT) begin
      if (count >= Cap || free_mask == '0) begin
        st = ST_FULL;
      end else begin
        for (int i = Cap - 1; i >= 0; i--) if (free_mask[i]) s = i[4:0];
        free_mask[s] = 1'b0;
        keys[s] = key;
        prv[s] = 0;
        if (count == 0) begin
          nxt[s] = 0;
          tail = s;
        end else begin
          nxt[s] = head;
          prv[head] = s;
        end
        head = s;
        count++;
      end
    end else if (count == 0) begin
      st = ST_EMPTY;
    end else if (cmd == CMD_DEL_KEY) begin
      s = head;
      for (int i = 0; i < count; i++) begin
        if (keys[s] == key) begin
          found = 1;
          break;
        end
        s = nxt[s];
      end
      if (found) unlink(s);
      else st = ST_NOT_FOUND;
    end else if (cmd == CMD_DEL_FIRST) begin
      unlink(head);
    end else begin
      unlink(tail);
    end
    if (count == 0) begin
      r = '{key: '0, last: 1'b1, empty: 1'b1, status: st};
      dump_q.push_back(r);
    end else begin
      s = head;
      for (int i = 0; i < count; i++) begin
        r = '{key: keys[s], last: i + 1 == count, empty: 1'b0, status: st};
        dump_q.push_back(r);
        s = nxt[s];
      end
    end
  endfunction

  function void check_item(dump_item_t got);
    dump_item_t exp;
    checked++;
    if (dump_q.size() == 0) begin
      $error("unexpected item: key %0h", got.key);
      errors++;
      return;
    end
    exp = dump_q.pop_front();
    if (got.key !== exp.key) begin
      $error("element_key exp %0d got %0d", $signed(exp.key), $signed(got.key));
      errors++;
    end
    if (got.last !== exp.last) begin
      $error("end_of_dump exp %0b got %0b", exp.last, got.last);
      errors++;
    end
    if (got.empty !== exp.empty) begin
      $error("list_empty exp %0b got %0b", exp.empty, got.empty);
      errors++;
    end
    if (got.status !== exp.status) begin
      $error("op_status exp %0d got %0d", exp.status, got.status);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  list_scoreboard sb = new();
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 71;
  int unsigned sent = 0;
  logic [31:0] key_pool[$];

  doubly_linked_list_engine dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_item('{key: m_axis_tdata, last: m_axis_tlast,
                        empty: m_axis_tuser[0], status: status_e'(m_axis_tuser[2:1])});
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send(cmd_e cmd, logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= key;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(cmd, key);
    if (cmd == CMD_INSERT) key_pool.push_back(key);
    sent++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.dump_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_cmd();
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(99);
    k = $urandom();
    if (r < 45) begin
      if ($urandom_range(3) == 0) k = $urandom_range(7);
      send(CMD_INSERT, k);
    end else if (r < 75) begin
      if (key_pool.size() != 0 && $urandom_range(3) != 0)
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      send(CMD_DEL_KEY, k);
    end else if (r < 88) begin
      send(CMD_DEL_FIRST, k);
    end else begin
      send(CMD_DEL_LAST, k);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // empty list on every delete, then single-element cases
    send(CMD_DEL_KEY, 32'h0);
    send(CMD_DEL_FIRST, 32'hFFFF_FFFF);
    send(CMD_DEL_LAST, 32'h0);
    send(CMD_INSERT, 32'h8000_0000);
    send(CMD_DEL_LAST, 32'h0);
    send(CMD_INSERT, 32'h7FFF_FFFF);
    send(CMD_DEL_FIRST, 32'h0);
    send(CMD_INSERT, 32'hFFFF_FFFF);
    send(CMD_INSERT, 32'h0);
    send(CMD_INSERT, 32'hFFFF_FFFF);
    send(CMD_DEL_KEY, 32'h1234_5678);
    send(CMD_DEL_KEY, 32'hFFFF_FFFF);
    send(CMD_DEL_KEY, 32'h0);
    send(CMD_INSERT, 32'h5);
    send(CMD_DEL_KEY, 32'h5);
    send(CMD_DEL_KEY, 32'hFFFF_FFFF);
    drain();
    // fill the pool, overflow, then empty it from both ends
    for (int i = 0; i < 34; i++) send(CMD_INSERT, $urandom());
    drain();
    for (int i = 0; i < 33; i++) send(i[0] ? CMD_DEL_LAST : CMD_DEL_FIRST, '0);
    key_pool.delete();
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 13 : phase == 1 ? 71 : 0;
      recv_idle_pct = phase == 0 ? 71 : phase == 1 ? 13 : 0;
      for (int i = 0; i < 22; i++) random_cmd();
      if (phase == 1) drain();
    end
    drain();
    $display("Sent %0d commands, checked %0d dump items", sent, sb.checked);
    $display("Covered empty, single, full-pool and random list traffic");
    if (sb.errors == 0 && sb.dump_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/dlle_pkg.sv
hdl/dlle_datapath.sv
hdl/dlle_ctrl.sv
hdl/doubly_linked_list_engine.sv
hdl/dlle_checker.sv
tb/sv/testbench.sv
